// ===== src/esutc_pkg.sv =====
// Shared types and constants for the Unix time to UTC date and time converter.
`timescale 1ns / 1ps
package esutc_pkg;

  localparam int NSTG = 14;

  typedef struct packed {
    logic signed [39:0] unix_seconds;
    logic [29:0]        nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] nanos_out;
    logic [3:0]  fraction_digits;
  } out_item_t;

  typedef struct packed {
    logic [NSTG:1] ld;
    logic          in_stall;
    logic          out_valid;
  } pipe_ctl_t;

  localparam logic signed [39:0] SEC_MIN    = -40'sd62135596800;
  localparam logic signed [39:0] SEC_MAX    = 40'sd253402300799;
  localparam logic [29:0]        NANO_LIMIT = 30'd1000000000;

  localparam logic [9:0]  DAY_DIV     = 10'd675;
  localparam logic [19:0] MEGA        = 20'd1000000;
  localparam logic [9:0]  KILO        = 10'd1000;
  localparam logic [11:0] HOUR_SECS   = 12'd3600;
  localparam logic [5:0]  MIN_SECS    = 6'd60;
  localparam logic [17:0] ERA_DAYS    = 18'd146097;
  localparam logic [10:0] QUAD_DAYS   = 11'd1460;
  localparam logic [15:0] CENT_DAYS   = 16'd36524;
  localparam logic [17:0] ERA_LAST    = 18'd146096;
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;
  localparam logic [8:0]  ERA_YEARS   = 9'd400;
  localparam logic [21:0] MARCH_SHIFT = 22'd306;

  localparam logic [22:0] RCP_DAY  = 23'((64'd1 << 32) / 64'd675);
  localparam logic [10:0] RCP_MEGA = 11'((64'd1 << 24) / 64'd15625);
  localparam logic [10:0] RCP_KILO = 11'((64'd1 << 17) / 64'd125);
  localparam logic [5:0]  RCP_HOUR = 6'((64'd1 << 13) / 64'd225);
  localparam logic [4:0]  RCP_ERA  = 5'((64'd1 << 22) / 64'd146097);
  localparam logic [6:0]  RCP_MIN  = 7'((64'd1 << 10) / 64'd15);
  localparam logic [7:0]  RCP_QUAD = 8'((64'd1 << 18) / 64'd1460);
  localparam logic [2:0]  RCP_CENT = 3'((64'd1 << 18) / 64'd36524);
  localparam logic [9:0]  RCP_YEAR = 10'((64'd1 << 18) / 64'd365);

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

endpackage

// ===== src/esutc_pipe_ctrl.sv =====
// Stage valid flags and per-stage load enables for the conversion pipeline.
`timescale 1ns / 1ps
module esutc_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  logic                 down_stall,
  output esutc_pkg::pipe_ctl_t ctl
);
  import esutc_pkg::*;

  logic [NSTG:1] vld;
  logic [NSTG:1] ready;
  logic          acc_in;
  logic          acc_out;

  for (genvar k = 1; k <= NSTG; k++) begin : g_ready
    assign ready[k] = !(down_stall && (&vld[NSTG:k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[1]) begin
        vld[1] <= up_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign acc_in        = up_valid && ready[1];
  assign acc_out       = vld[NSTG] && !down_stall;
  assign ctl.ld        = ready;
  assign ctl.in_stall  = !ready[1];
  assign ctl.out_valid = vld[NSTG];

`ifndef ASSERT_OFF
  a_item_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) ==
              $past($countones(vld)) + int'($past(acc_in)) - int'($past(acc_out))))
    else $error("Pipeline occupancy does not match accepted and delivered items.");
`endif

endmodule

// ===== src/epoch_seconds_to_utc_date_time_unit.sv =====
// Unix seconds and nanoseconds to UTC civil date and time, 14-stage pipeline.
// Each accepted item passes through the stage registers s1 to s13 and then the result register.
// Throughput: one item per cycle while date_stall is low; each division by a constant is a reciprocal
// multiply stage and a correction stage, and the chain of them sets the depth.
// Reset clears the stage valid flags only; datapath registers are not reset.
`timescale 1ns / 1ps
module epoch_seconds_to_utc_date_time_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 time_valid,
  output logic                 time_stall,
  input  esutc_pkg::in_item_t  time_item,
  output logic                 date_valid,
  input  logic                 date_stall,
  output esutc_pkg::out_item_t date_item
);
  import esutc_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [29:0] ns;
    logic [3:0]  digits;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  era;
  } side_t;

  function automatic logic [1:0] group_zeros(input logic [9:0] v, input logic [17:0] p10,
                                             input logic [15:0] p100);
    logic [6:0] q10;
    logic [3:0] q100;
    q10  = p10[17:11];
    q100 = p100[15:12];
    if (v == 10'(q100 * 7'd100)) begin
      return 2'd2;
    end else if (v == 10'(q10 * 4'd10)) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  pipe_ctl_t ctl;

  side_t side      [2:NSTG-1];
  side_t side_next [2:NSTG-1];

  logic signed [39:0] s1_secs;
  logic [29:0]        s1_ns;

  logic [38:0] s2_sh;
  logic [34:0] s2_nprod;

  logic [54:0] s3_dprod;
  logic [31:0] s3_t;
  logic [6:0]  s3_lo;
  logic [9:0]  s3_na;
  logic [19:0] s3_nr;

  logic [21:0] s4_days;
  logic [16:0] s4_sod;
  logic [27:0] s4_nprod;
  logic [9:0]  s4_na;
  logic [19:0] s4_nr;

  logic [21:0] s5_z;
  logic [18:0] s5_hprod;
  logic [16:0] s5_sod;
  logic [9:0]  s5_grp [3];

  logic [26:0] s6_zprod;
  logic [21:0] s6_z;
  logic [11:0] s6_ms;
  logic [9:0]  s6_grp  [3];
  logic [17:0] s6_p10  [3];
  logic [15:0] s6_p100 [3];

  logic [17:0] s7_doe;
  logic [16:0] s7_mprod;
  logic [11:0] s7_ms;

  logic [25:0] s8_p1;
  logic [20:0] s8_p2;
  logic        s8_q4;
  logic [17:0] s8_doe;

  logic [6:0]  s9_q1;
  logic [2:0]  s9_q2;
  logic        s9_q4;
  logic [17:0] s9_doe;

  logic [17:0] s10_yn;
  logic [17:0] s10_doe;

  logic [27:0] s11_yprod;
  logic [17:0] s11_yn;
  logic [17:0] s11_doe;

  logic [8:0]  s12_yoe;
  logic [17:0] s12_doe;

  logic [8:0]  s13_doy;
  logic [8:0]  s13_yoe;

  out_item_t res;
  out_item_t res_next;

  logic [40:0] sh_wide;
  logic        in_range;

  logic [10:0] mega_est;
  logic [29:0] mega_rem;
  logic        mega_fix;
  logic [10:0] mega_q;
  logic [29:0] mega_r;

  logic [22:0] day_est;
  logic [31:0] day_rem;
  logic        day_fix;
  logic [22:0] day_q;
  logic [31:0] day_r;

  logic [10:0] kilo_est;
  logic [19:0] kilo_rem;
  logic        kilo_fix;
  logic [10:0] kilo_q;
  logic [19:0] kilo_r;

  logic [5:0]  hour_est;
  logic [16:0] hour_rem;
  logic        hour_fix;
  logic [4:0]  hour_q;
  logic [16:0] hour_r;

  logic [4:0]  era_est;
  logic [21:0] era_rem;
  logic        era_fix;
  logic [4:0]  era_q;
  logic [21:0] era_r;
  logic [1:0]  tz_a;
  logic [1:0]  tz_b;
  logic [1:0]  tz_c;
  logic [3:0]  digits_c;

  logic [6:0]  min_est;
  logic [11:0] min_rem;
  logic        min_fix;
  logic [5:0]  min_q;
  logic [5:0]  sec_r;

  logic [7:0]  quad_est;
  logic [17:0] quad_rem;
  logic [2:0]  cent_est;
  logic [17:0] cent_rem;

  logic [9:0]  yoe_est;
  logic [17:0] yoe_rem;
  logic        yoe_fix;

  logic [1:0]  cent_cnt;

  logic [3:0]  mp;
  logic [3:0]  mon;

  esutc_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (time_valid),
    .down_stall (date_stall),
    .ctl        (ctl)
  );

  assign time_stall = ctl.in_stall;
  assign date_valid = ctl.out_valid;
  assign date_item  = res;

  always_comb begin
    side_next[2]    = '0;
    side_next[2].ok = in_range;
    side_next[2].ns = s1_ns;
    for (int k = 3; k < NSTG; k++) begin
      side_next[k] = side[k-1];
    end
    side_next[6].hour   = hour_q;
    side_next[7].era    = era_q;
    side_next[7].digits = digits_c;
    side_next[8].minute = min_q;
    side_next[8].second = sec_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 2; k < NSTG; k++) begin
      if (ctl.ld[k]) begin
        side[k] <= side_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      s1_secs <= time_item.unix_seconds;
      s1_ns   <= time_item.nanoseconds;
    end
  end

  // Shift the seconds so that 0001-01-01T00:00:00 is zero.
  always_comb begin
    sh_wide  = 41'(s1_secs) - 41'(SEC_MIN);
    in_range = (s1_secs >= SEC_MIN) && (s1_secs <= SEC_MAX) && (s1_ns < NANO_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      s2_sh    <= sh_wide[38:0];
      s2_nprod <= 35'(s1_ns[29:6] * RCP_MEGA);
    end
  end

  always_comb begin
    mega_est = s2_nprod[34:24];
    mega_rem = side[2].ns - 30'(mega_est * MEGA);
    mega_fix = (mega_rem >= 30'(MEGA));
    mega_q   = mega_est + 11'(mega_fix);
    mega_r   = mega_rem - (mega_fix ? 30'(MEGA) : 30'd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      s3_dprod <= 55'(s2_sh[38:7] * RCP_DAY);
      s3_t     <= s2_sh[38:7];
      s3_lo    <= s2_sh[6:0];
      s3_na    <= mega_q[9:0];
      s3_nr    <= mega_r[19:0];
    end
  end

  always_comb begin
    day_est = s3_dprod[54:32];
    day_rem = s3_t - 32'(day_est * DAY_DIV);
    day_fix = (day_rem >= 32'(DAY_DIV));
    day_q   = day_est + 23'(day_fix);
    day_r   = day_rem - (day_fix ? 32'(DAY_DIV) : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      s4_days  <= day_q[21:0];
      s4_sod   <= {day_r[9:0], s3_lo};
      s4_nprod <= 28'(s3_nr[19:3] * RCP_KILO);
      s4_na    <= s3_na;
      s4_nr    <= s3_nr;
    end
  end

  always_comb begin
    kilo_est = s4_nprod[27:17];
    kilo_rem = s4_nr - 20'(kilo_est * KILO);
    kilo_fix = (kilo_rem >= 20'(KILO));
    kilo_q   = kilo_est + 11'(kilo_fix);
    kilo_r   = kilo_rem - (kilo_fix ? 20'(KILO) : 20'd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      s5_z      <= s4_days + MARCH_SHIFT;
      s5_hprod  <= 19'(s4_sod[16:4] * RCP_HOUR);
      s5_sod    <= s4_sod;
      s5_grp[0] <= s4_na;
      s5_grp[1] <= kilo_q[9:0];
      s5_grp[2] <= kilo_r[9:0];
    end
  end

  always_comb begin
    hour_est = s5_hprod[18:13];
    hour_rem = s5_sod - 17'(hour_est * HOUR_SECS);
    hour_fix = (hour_rem >= 17'(HOUR_SECS));
    hour_q   = 5'(hour_est + 6'(hour_fix));
    hour_r   = hour_rem - (hour_fix ? 17'(HOUR_SECS) : 17'd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      s6_zprod <= 27'(s5_z * RCP_ERA);
      s6_z     <= s5_z;
      s6_ms    <= hour_r[11:0];
      for (int i = 0; i < 3; i++) begin
        s6_grp[i]  <= s5_grp[i];
        s6_p10[i]  <= 18'(s5_grp[i] * 8'd205);
        s6_p100[i] <= 16'(s5_grp[i] * 6'd41);
      end
    end
  end

  always_comb begin
    era_est = s6_zprod[26:22];
    era_rem = s6_z - 22'(era_est * ERA_DAYS);
    era_fix = (era_rem >= 22'(ERA_DAYS));
    era_q   = era_est + 5'(era_fix);
    era_r   = era_rem - (era_fix ? 22'(ERA_DAYS) : 22'd0);
    tz_a    = group_zeros(s6_grp[0], s6_p10[0], s6_p100[0]);
    tz_b    = group_zeros(s6_grp[1], s6_p10[1], s6_p100[1]);
    tz_c    = group_zeros(s6_grp[2], s6_p10[2], s6_p100[2]);
    priority if (s6_grp[2] != 10'd0) begin
      digits_c = 4'd9 - 4'(tz_c);
    end else if (s6_grp[1] != 10'd0) begin
      digits_c = 4'd6 - 4'(tz_b);
    end else if (s6_grp[0] != 10'd0) begin
      digits_c = 4'd3 - 4'(tz_a);
    end else begin
      digits_c = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[7]) begin
      s7_doe   <= era_r[17:0];
      s7_mprod <= 17'(s6_ms[11:2] * RCP_MIN);
      s7_ms    <= s6_ms;
    end
  end

  always_comb begin
    min_est = s7_mprod[16:10];
    min_rem = s7_ms - 12'(min_est * MIN_SECS);
    min_fix = (min_rem >= 12'(MIN_SECS));
    min_q   = 6'(min_est + 7'(min_fix));
    sec_r   = 6'(min_rem - (min_fix ? 12'(MIN_SECS) : 12'd0));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[8]) begin
      s8_p1  <= 26'(s7_doe * RCP_QUAD);
      s8_p2  <= 21'(s7_doe * RCP_CENT);
      s8_q4  <= (s7_doe == ERA_LAST);
      s8_doe <= s7_doe;
    end
  end

  always_comb begin
    quad_est = s8_p1[25:18];
    quad_rem = s8_doe - 18'(quad_est * QUAD_DAYS);
    cent_est = s8_p2[20:18];
    cent_rem = s8_doe - 18'(cent_est * CENT_DAYS);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[9]) begin
      s9_q1  <= 7'(quad_est + 8'(quad_rem >= 18'(QUAD_DAYS)));
      s9_q2  <= cent_est + 3'(cent_rem >= 18'(CENT_DAYS));
      s9_q4  <= s8_q4;
      s9_doe <= s8_doe;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[10]) begin
      s10_yn  <= s9_doe - 18'(s9_q1) + 18'(s9_q2) - 18'(s9_q4);
      s10_doe <= s9_doe;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[11]) begin
      s11_yprod <= 28'(s10_yn * RCP_YEAR);
      s11_yn    <= s10_yn;
      s11_doe   <= s10_doe;
    end
  end

  always_comb begin
    yoe_est = s11_yprod[27:18];
    yoe_rem = s11_yn - 18'(yoe_est * YEAR_DAYS);
    yoe_fix = (yoe_rem >= 18'(YEAR_DAYS));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[12]) begin
      s12_yoe <= 9'(yoe_est + 10'(yoe_fix));
      s12_doe <= s11_doe;
    end
  end

  always_comb begin
    cent_cnt = 2'(s12_yoe >= 9'd100) + 2'(s12_yoe >= 9'd200) + 2'(s12_yoe >= 9'd300);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[13]) begin
      s13_doy <= 9'(s12_doe - (18'(s12_yoe * YEAR_DAYS) + 18'(s12_yoe[8:2]) - 18'(cent_cnt)));
      s13_yoe <= s12_yoe;
    end
  end

  // Months are counted from March, so January and February close the year.
  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      mp = mp + 4'(s13_doy >= MONTH_START[i]);
    end
    mon      = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    res_next = '0;
    if (side[NSTG-1].ok) begin
      res_next.valid_res       = 1'b1;
      res_next.year            = 14'(s13_yoe) + 14'(side[NSTG-1].era * ERA_YEARS)
                                 + 14'(mon <= 4'd2);
      res_next.month           = mon;
      res_next.day             = 5'(s13_doy - MONTH_START[mp] + 9'd1);
      res_next.hour            = side[NSTG-1].hour;
      res_next.minute          = side[NSTG-1].minute;
      res_next.second          = side[NSTG-1].second;
      res_next.nanos_out       = side[NSTG-1].ns;
      res_next.fraction_digits = side[NSTG-1].digits;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[NSTG]) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    date_valid && !date_item.valid_res |-> (date_item == '0))
    else $error("An out-of-range result carries nonzero fields.");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    date_valid && date_item.valid_res |->
      (date_item.year >= 14'd1) && (date_item.year <= 14'd9999) &&
      (date_item.month >= 4'd1) && (date_item.month <= 4'd12) &&
      (date_item.day >= 5'd1) && (date_item.hour <= 5'd23) &&
      (date_item.minute <= 6'd59) && (date_item.second <= 6'd59))
    else $error("A valid result has a date or time field out of range.");

  a_frac_digits: assert property (@(posedge clk) disable iff (rst)
    date_valid && date_item.valid_res |->
      ((date_item.fraction_digits == 4'd0) == (date_item.nanos_out == 30'd0)) &&
      (date_item.fraction_digits <= 4'd9))
    else $error("Fraction digit count disagrees with the nanoseconds.");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the Unix time to UTC date and time converter: directed and random stimulus.
`timescale 1ns / 1ps
module testbench;
  import esutc_pkg::*;

  localparam longint FIRST_SEC  = -64'sd62135596800;
  localparam longint LAST_SEC   = 64'sd253402300799;
  localparam longint NANO_RANGE = 64'sd1000000000;
  localparam longint DAY_SECS   = 64'sd86400;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     DRAIN_CYCLES = 30;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       time_valid = 1'b0;
  logic       time_stall;
  in_item_t   time_item = '0;
  logic       date_valid;
  logic       date_stall = 1'b0;
  out_item_t  date_item;

  out_item_t  expected_dates[$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         gap_max = 0;
  int         stall_level = 0;
  logic [31:0] stall_pattern = '0;
  int         pattern_left = 0;
  int         quiet_cycles = 0;

  epoch_seconds_to_utc_date_time_unit dut (
    .clk(clk),
    .rst(rst),
    .time_valid(time_valid),
    .time_stall(time_stall),
    .time_item(time_item),
    .date_valid(date_valid),
    .date_stall(date_stall),
    .date_item(date_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t predict_date(in_item_t it);
    longint secs, nanos, day_num, sec_of_day, shifted, era_idx, day_of_era;
    longint year_of_era, day_of_year, month_idx, cal_year, cal_month, cal_day, rest;
    int digits;
    out_item_t r;
    r = '0;
    secs = {{24{it.unix_seconds[39]}}, it.unix_seconds};
    nanos = {34'd0, it.nanoseconds};
    if (secs < FIRST_SEC || secs > LAST_SEC || nanos >= NANO_RANGE) return r;
    day_num = secs / DAY_SECS;
    sec_of_day = secs % DAY_SECS;
    if (sec_of_day < 0) begin
      day_num = day_num - 1;
      sec_of_day = sec_of_day + DAY_SECS;
    end
    shifted = day_num + 64'sd719468;
    era_idx = (shifted >= 0 ? shifted : shifted - 64'sd146096) / 64'sd146097;
    day_of_era = shifted - era_idx * 64'sd146097;
    year_of_era = (day_of_era - day_of_era / 64'sd1460 + day_of_era / 64'sd36524
                   - day_of_era / 64'sd146096) / 64'sd365;
    day_of_year = day_of_era - (64'sd365 * year_of_era + year_of_era / 64'sd4
                                - year_of_era / 64'sd100);
    month_idx = (64'sd5 * day_of_year + 64'sd2) / 64'sd153;
    cal_day = day_of_year - (64'sd153 * month_idx + 64'sd2) / 64'sd5 + 64'sd1;
    cal_month = month_idx < 10 ? month_idx + 64'sd3 : month_idx - 64'sd9;
    cal_year = year_of_era + era_idx * 64'sd400 + (cal_month <= 2 ? 64'sd1 : 64'sd0);
    digits = 0;
    if (nanos != 0) begin
      digits = 9;
      rest = nanos;
      while (rest % 10 == 0) begin
        rest = rest / 10;
        digits--;
      end
    end
    r.valid_res = 1'b1;
    r.year = cal_year[13:0];
    r.month = cal_month[3:0];
    r.day = cal_day[4:0];
    r.hour = 5'(sec_of_day / 3600);
    r.minute = 6'((sec_of_day % 3600) / 60);
    r.second = 6'(sec_of_day % 60);
    r.nanos_out = nanos[29:0];
    r.fraction_digits = 4'(digits);
    return r;
  endfunction

  function automatic in_item_t make_time(longint secs, longint nanos);
    in_item_t it;
    it.unix_seconds = secs[39:0];
    it.nanoseconds = nanos[29:0];
    return it;
  endfunction

  task automatic send_time(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      burst_left = $urandom_range(16, 1);
      if (gap > 0) begin
        @(negedge clk);
        time_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    time_valid = 1'b1;
    time_item = it;
    @(posedge clk);
    while (time_stall) @(posedge clk);
    expected_dates.push_back(predict_date(it));
    burst_left--;
  endtask

  // The receiver stalls from a 32-bit random pattern whose density follows stall_level.
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      case (stall_level)
        0: stall_pattern = '0;
        1: stall_pattern = $urandom & $urandom & $urandom;
        2: stall_pattern = $urandom;
        default: stall_pattern = $urandom | $urandom;
      endcase
      pattern_left = 32;
    end
    date_stall = rst ? 1'b0 : stall_pattern[0];
    stall_pattern = stall_pattern >> 1;
    pattern_left--;
  end

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && date_valid && !date_stall) begin
      if (expected_dates.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual %p", $time, date_item);
      end else begin
        want = expected_dates.pop_front();
        report_field("valid_res", want.valid_res, date_item.valid_res);
        report_field("year", want.year, date_item.year);
        report_field("month", want.month, date_item.month);
        report_field("day", want.day, date_item.day);
        report_field("hour", want.hour, date_item.hour);
        report_field("minute", want.minute, date_item.minute);
        report_field("second", want.second, date_item.second);
        report_field("nanos_out", want.nanos_out, date_item.nanos_out);
        report_field("fraction_digits", want.fraction_digits, date_item.fraction_digits);
      end
    end
  end

  always @(posedge clk) begin
    if ((time_valid && !time_stall) || (date_valid && !date_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic test_range_edges();
    send_time(make_time(FIRST_SEC, 0));
    send_time(make_time(FIRST_SEC - 1, 0));
    send_time(make_time(LAST_SEC, 999999999));
    send_time(make_time(LAST_SEC + 1, 0));
    send_time(make_time(0, 0));
    send_time(make_time(-1, 5));
    send_time(make_time(-DAY_SECS, 0));
    send_time(make_time(-DAY_SECS - 1, 0));
    send_time(make_time(64'sd549755813887, 0));
    send_time(make_time(-64'sd549755813888, 0));
  endtask

  task automatic test_leap_days();
    send_time(make_time(64'sd951696000, 0));
    send_time(make_time(64'sd951782400, 0));
    send_time(make_time(-64'sd2203891200 - DAY_SECS, 0));
    send_time(make_time(-64'sd2203891200, 0));
    send_time(make_time(64'sd1709164799, 0));
  endtask

  task automatic test_fraction_digits();
    send_time(make_time(86399, 1));
    send_time(make_time(3600, 999999999));
    send_time(make_time(60, 1000000000));
    send_time(make_time(59, 64'sd1073741823));
    send_time(make_time(1234567890, 100000000));
    send_time(make_time(1234567890, 10));
    send_time(make_time(1234567890, 500000000));
    send_time(make_time(1234567890, 123456780));
  endtask

  task automatic test_random_instants(int count, int sender_gap, int receiver_level);
    longint unsigned span, raw;
    longint secs, nanos;
    int pick;
    gap_max = sender_gap;
    stall_level = receiver_level;
    span = longint'(LAST_SEC - FIRST_SEC + 1);
    for (int i = 0; i < count; i++) begin
      raw = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 70) begin
        secs = FIRST_SEC + longint'(raw % span);
      end else if (pick < 80) begin
        secs = ($urandom_range(1) ? FIRST_SEC : LAST_SEC) + longint'($urandom_range(4000)) - 2000;
      end else if (pick < 90) begin
        secs = {{24{raw[39]}}, raw[39:0]};
      end else begin
        secs = (FIRST_SEC / DAY_SECS + longint'(raw % (span / DAY_SECS))) * DAY_SECS;
        case ($urandom_range(2))
          0: secs = secs + 86399;
          1: secs = secs + longint'($urandom_range(86399));
          default: ;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 60) nanos = $urandom_range(999999999);
      else if (pick < 75) nanos = longint'($urandom_range(9999)) * (64'sd10 ** $urandom_range(5));
      else if (pick < 85) nanos = 0;
      else nanos = $urandom_range(1073741823, 1000000000);
      if (nanos >= NANO_RANGE && pick < 85) nanos = nanos % NANO_RANGE;
      send_time(make_time(secs, nanos));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    gap_max = 3;
    stall_level = 1;
    test_range_edges();
    test_leap_days();
    test_fraction_digits();
    test_random_instants(350, 0, 0);
    test_random_instants(350, 12, 3);
    test_random_instants(350, 6, 0);
    test_random_instants(350, 0, 2);
    @(negedge clk);
    time_valid = 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
